@@ rtl/decimal_integer_list_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// Decimal integer list parser - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_LIST_PARSER_CORE_DEFINES_SVH
`define DECIMAL_INTEGER_LIST_PARSER_CORE_DEFINES_SVH

// same-cycle implication
`define DILP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DILP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dilp_pkg.sv @@
// ----------------------------------------------------------------------------
// dilp_pkg
// Types and constants of the decimal integer list parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dilp_pkg;

  localparam int CharW  = 8;
  localparam int MagW   = 63;
  localparam int ValueW = 64;
  localparam int CountW = 16;
  localparam int AddrW  = 3;
  localparam int DataW  = 32;

  localparam logic [CharW-1:0]  CHAR_TERM  = 8'h00;
  localparam logic [CharW-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CharW-1:0]  CHAR_NINE  = 8'h39;
  localparam logic [CharW-1:0]  CHAR_MINUS = 8'h2D;

  localparam logic [MagW-1:0]   MAG_MAX    = {MagW{1'b1}};
  localparam logic [CountW-1:0] MAX_VALUES_RESET = 16'd16;

  localparam logic [AddrW-1:0]  ADDR_MAX_VALUES = 3'd0;

  typedef enum logic [1:0] {
    CLS_TERM  = 2'd0,
    CLS_DIGIT = 2'd1,
    CLS_MINUS = 2'd2,
    CLS_SEP   = 2'd3
  } char_cls_t;

  typedef struct packed {
    char_cls_t   cls;
    logic [3:0]  digit;
  } entry_t;

  typedef struct packed {
    logic                     value_valid;
    logic signed [ValueW-1:0] parsed_value;
    logic [CountW-1:0]        value_index;
    logic                     overflow;
    logic                     done_res;
    logic [CountW-1:0]        total_count;
  } result_t;

  function automatic entry_t classify(input logic [CharW-1:0] ch);
    entry_t e;
    e.digit = ch[3:0];
    priority if (ch == CHAR_TERM) begin
      e.cls = CLS_TERM;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      e.cls = CLS_DIGIT;
    end else if (ch == CHAR_MINUS) begin
      e.cls = CLS_MINUS;
    end else begin
      e.cls = CLS_SEP;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

@@ rtl/dilp_front.sv @@
// ----------------------------------------------------------------------------
// dilp_front
// Accepts characters, classifies them and queues one word per character.
// ----------------------------------------------------------------------------
`default_nettype none

module dilp_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire logic [dilp_pkg::CharW-1:0]   in_char_code,
  output logic                              in_stall,
  output dilp_pkg::entry_t                  q_word,
  output logic                              q_valid,
  input  wire logic                         q_pop
);

  localparam int PtrW = (QUEUE_DEPTH > 2) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

  dilp_pkg::entry_t q_mem [QUEUE_DEPTH];

  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            push;

  assign in_stall = (cnt_r == CntFull);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_word   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrLast) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrLast) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= dilp_pkg::classify(in_char_code);
    end
  end

endmodule

`default_nettype wire

@@ rtl/dilp_back.sv @@
// ----------------------------------------------------------------------------
// dilp_back
// Number accumulator, list bookkeeping and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dilp_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire dilp_pkg::entry_t              q_word,
  input  wire logic                          q_valid,
  output logic                               q_pop,
  input  wire logic [dilp_pkg::CountW-1:0]   max_values,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output dilp_pkg::result_t                  res
);

  localparam int MagW = dilp_pkg::MagW;
  localparam int AccW = MagW + 4;

  logic                         in_number_r, in_number_nxt;
  logic                         neg_r, neg_nxt;
  logic [MagW-1:0]              mag_r, mag_nxt;
  logic                         sat_r, sat_nxt;
  logic [dilp_pkg::CountW-1:0]  found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  dilp_pkg::result_t            res_r, res_nxt;

  logic                         full;
  logic                         emit;
  logic                         flush;
  logic [AccW-1:0]              acc;
  logic                         acc_ovf;
  logic signed [dilp_pkg::ValueW-1:0] signed_val;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign full    = (found_r >= max_values);
  assign flush   = in_number_r && !full;
  assign acc     = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + AccW'(q_word.digit);
  assign acc_ovf = |acc[AccW-1:MagW];
  assign signed_val = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});

  always_comb begin
    in_number_nxt = in_number_r;
    neg_nxt       = neg_r;
    mag_nxt       = mag_r;
    sat_nxt       = sat_r;
    found_nxt     = found_r;
    emit          = 1'b0;
    res_nxt       = res_r;

    if (q_pop) begin
      if (q_word.cls == dilp_pkg::CLS_TERM) begin
        emit                 = 1'b1;
        res_nxt.value_valid  = flush;
        res_nxt.parsed_value = flush ? signed_val : '0;
        res_nxt.value_index  = flush ? found_r : '0;
        res_nxt.overflow     = flush && sat_r;
        res_nxt.done_res     = 1'b1;
        res_nxt.total_count  = found_r + dilp_pkg::CountW'(flush);
        in_number_nxt        = 1'b0;
        neg_nxt              = 1'b0;
        mag_nxt              = '0;
        sat_nxt              = 1'b0;
        found_nxt            = '0;
      end else if (!full) begin
        if (in_number_r) begin
          if (q_word.cls == dilp_pkg::CLS_DIGIT) begin
            if (sat_r || acc_ovf) begin
              mag_nxt = dilp_pkg::MAG_MAX;
              sat_nxt = 1'b1;
            end else begin
              mag_nxt = acc[MagW-1:0];
            end
          end else begin
            emit                 = 1'b1;
            res_nxt.value_valid  = 1'b1;
            res_nxt.parsed_value = signed_val;
            res_nxt.value_index  = found_r;
            res_nxt.overflow     = sat_r;
            res_nxt.done_res     = 1'b0;
            res_nxt.total_count  = '0;
            found_nxt            = found_r + 1'b1;
            in_number_nxt        = 1'b0;
            neg_nxt              = 1'b0;
            mag_nxt              = '0;
            sat_nxt              = 1'b0;
          end
        end else if (q_word.cls == dilp_pkg::CLS_MINUS) begin
          in_number_nxt = 1'b1;
          neg_nxt       = 1'b1;
          mag_nxt       = '0;
          sat_nxt       = 1'b0;
        end else if (q_word.cls == dilp_pkg::CLS_DIGIT) begin
          in_number_nxt = 1'b1;
          neg_nxt       = 1'b0;
          mag_nxt       = MagW'(q_word.digit);
          sat_nxt       = 1'b0;
        end
      end
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_number_r <= 1'b0;
      neg_r       <= 1'b0;
      mag_r       <= '0;
      sat_r       <= 1'b0;
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      in_number_r <= in_number_nxt;
      neg_r       <= neg_nxt;
      mag_r       <= mag_nxt;
      sat_r       <= sat_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res_r <= res_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/decimal_integer_list_parser_core.sv @@
// ----------------------------------------------------------------------------
// decimal_integer_list_parser_core
// ASCII signed decimal integer list parser with a configuration register.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | in_char_code
//  out      | out_valid / out_stall| out_value_valid .. out_total_count
//  cfg      | psel/penable/pwrite  | paddr, pwdata, prdata (max_values @ 0x0)
//
//  One character per cycle while in_stall is low; a word is written into the
//  front queue when accepted and popped unless a valid output is stalled.
//  The multiply-by-ten add of the 63-bit magnitude sets the back stage path.
//  Reset is synchronous, active low; max_values returns to 16.
//  The front queue absorbs a stalled output; in_stall rises when it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_integer_list_parser_core #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dilp_pkg::CharW-1:0]          in_char_code,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_value_valid,
  output logic signed [dilp_pkg::ValueW-1:0]       out_parsed_value,
  output logic [dilp_pkg::CountW-1:0]              out_value_index,
  output logic                                     out_overflow,
  output logic                                     out_done_res,
  output logic [dilp_pkg::CountW-1:0]              out_total_count,
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dilp_pkg::AddrW-1:0]          paddr,
  input  wire logic [dilp_pkg::DataW-1:0]          pwdata,
  output logic [dilp_pkg::DataW-1:0]               prdata,
  output logic                                     pready
);

  logic [dilp_pkg::CountW-1:0] max_values_r;
  dilp_pkg::entry_t            q_word;
  logic                        q_valid;
  logic                        q_pop;
  dilp_pkg::result_t           res;

  assign pready = 1'b1;
  assign prdata = (paddr == dilp_pkg::ADDR_MAX_VALUES)
                ? dilp_pkg::DataW'(max_values_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_values_r <= dilp_pkg::MAX_VALUES_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == dilp_pkg::ADDR_MAX_VALUES) begin
      max_values_r <= pwdata[dilp_pkg::CountW-1:0];
    end
  end

  dilp_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .q_word       (q_word),
    .q_valid      (q_valid),
    .q_pop        (q_pop)
  );

  dilp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_word     (q_word),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .max_values (max_values_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res        (res)
  );

  assign out_value_valid  = res.value_valid;
  assign out_parsed_value = res.parsed_value;
  assign out_value_index  = res.value_index;
  assign out_overflow     = res.overflow;
  assign out_done_res     = res.done_res;
  assign out_total_count  = res.total_count;

endmodule

`default_nettype wire

@@ rtl/dilp_checker.sv @@
// ----------------------------------------------------------------------------
// dilp_checker
// Port-level checks on the parser's result stream.
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_integer_list_parser_core_defines.svh"

module dilp_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic                          out_value_valid,
  input  wire logic [dilp_pkg::ValueW-1:0]   out_parsed_value,
  input  wire logic [dilp_pkg::CountW-1:0]   out_value_index,
  input  wire logic                          out_overflow,
  input  wire logic                          out_done_res,
  input  wire logic [dilp_pkg::CountW-1:0]   out_total_count
);

  `DILP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_parsed_value), "stalled word changed")
  `DILP_ASSERT_IMPLY(a_empty_zero, out_valid && !out_value_valid, out_parsed_value == '0 && out_value_index == '0 && !out_overflow, "empty word carries data")
  `DILP_ASSERT_IMPLY(a_sep_word, out_valid && !out_done_res, out_value_valid && out_total_count == '0, "separator word malformed")
  `DILP_ASSERT_IMPLY(a_sat_value, out_valid && out_overflow, out_parsed_value == 64'h7FFF_FFFF_FFFF_FFFF || out_parsed_value == 64'h8000_0000_0000_0001, "overflow without saturated value")
  `DILP_ASSERT_IMPLY(a_done_count, out_valid && out_done_res && out_value_valid, out_total_count == out_value_index + 16'd1, "final count mismatch")

endmodule

bind decimal_integer_list_parser_core dilp_checker u_dilp_checker (.*);

`default_nettype wire

@@ tb/tb_decimal_integer_list_parser_core.sv @@
// ----------------------------------------------------------------------------
// tb_decimal_integer_list_parser_core
// Self-checking bench for the ASCII signed decimal integer list parser.
// Character strings are queued, sent one character per handshake with random
// gaps and output stalls, and every output word is compared field by field
// against an in-bench parser model. max_values is swept through several
// settings over the APB port, with each write read back.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_decimal_integer_list_parser_core;

  localparam int         CycleLimit = 200000;
  localparam int         SettleCycles = 8;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic [dilp_pkg::CharW-1:0]          in_char_code = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic                                out_value_valid;
  logic signed [dilp_pkg::ValueW-1:0]  out_parsed_value;
  logic [dilp_pkg::CountW-1:0]         out_value_index;
  logic                                out_overflow;
  logic                                out_done_res;
  logic [dilp_pkg::CountW-1:0]         out_total_count;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [dilp_pkg::AddrW-1:0]          paddr = '0;
  logic [dilp_pkg::DataW-1:0]          pwdata = '0;
  logic [dilp_pkg::DataW-1:0]          prdata;
  logic                                pready;

  decimal_integer_list_parser_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_char_code     (in_char_code),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value_valid  (out_value_valid),
    .out_parsed_value (out_parsed_value),
    .out_value_index  (out_value_index),
    .out_overflow     (out_overflow),
    .out_done_res     (out_done_res),
    .out_total_count  (out_total_count),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #5 clk = ~clk;

  logic [dilp_pkg::CharW-1:0] char_queue[$];
  dilp_pkg::result_t          expected_results[$];
  int               queued_count = 0;
  int               accepted_count = 0;
  int               error_count = 0;
  int               cycle_count = 0;
  bit               in_taken = 1'b0;
  bit               steady = 1'b0;

  // parser model state
  logic [dilp_pkg::CountW-1:0] max_values_q = dilp_pkg::MAX_VALUES_RESET;
  bit                          num_open = 1'b0;
  bit                          num_negative = 1'b0;
  logic [dilp_pkg::MagW-1:0]   num_mag = '0;
  bit                          num_sat = 1'b0;
  logic [dilp_pkg::CountW-1:0] list_len = '0;

  task automatic report(input string msg);
    $display("%0t ns: %s", $time, msg);
    error_count++;
  endtask

  task automatic close_number();
    num_open = 1'b0;
    num_negative = 1'b0;
    num_mag = '0;
    num_sat = 1'b0;
  endtask

  function automatic dilp_pkg::result_t finished_number();
    dilp_pkg::result_t r;
    logic [dilp_pkg::ValueW-1:0] mag64;
    mag64 = {1'b0, num_mag};
    r = '0;
    r.value_valid = 1'b1;
    r.parsed_value = num_negative ? -mag64 : mag64;
    r.value_index = list_len;
    r.overflow = num_sat;
    return r;
  endfunction

  task automatic parse_char(input logic [dilp_pkg::CharW-1:0] ch);
    dilp_pkg::result_t r;
    bit is_dig;
    logic [dilp_pkg::ValueW-1:0] dig;
    is_dig = (ch >= dilp_pkg::CHAR_ZERO) && (ch <= dilp_pkg::CHAR_NINE);
    dig = is_dig ? dilp_pkg::ValueW'(ch - dilp_pkg::CHAR_ZERO) : '0;
    r = '0;
    if (ch == dilp_pkg::CHAR_TERM) begin
      if (num_open && list_len < max_values_q) begin
        r = finished_number();
        list_len++;
      end
      r.done_res = 1'b1;
      r.total_count = list_len;
      expected_results.push_back(r);
      close_number();
      list_len = '0;
    end else if (list_len < max_values_q) begin
      if (num_open) begin
        if (is_dig) begin
          if (num_sat || {1'b0, num_mag} > ({1'b0, dilp_pkg::MAG_MAX} - dig) / 10) begin
            num_mag = dilp_pkg::MAG_MAX;
            num_sat = 1'b1;
          end else begin
            num_mag = dilp_pkg::MagW'({1'b0, num_mag} * 10 + dig);
          end
        end else begin
          expected_results.push_back(finished_number());
          list_len++;
          close_number();
        end
      end else if (ch == dilp_pkg::CHAR_MINUS) begin
        num_open = 1'b1;
        num_negative = 1'b1;
        num_mag = '0;
        num_sat = 1'b0;
      end else if (is_dig) begin
        num_open = 1'b1;
        num_negative = 1'b0;
        num_mag = dilp_pkg::MagW'(dig);
        num_sat = 1'b0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) begin
      report($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic check_word();
    dilp_pkg::result_t want;
    if (expected_results.size() == 0) begin
      report("output word with nothing expected");
      return;
    end
    want = expected_results.pop_front();
    check_field("value_valid", out_value_valid, want.value_valid);
    check_field("parsed_value", out_parsed_value, want.parsed_value);
    check_field("value_index", out_value_index, want.value_index);
    check_field("overflow", out_overflow, want.overflow);
    check_field("done_res", out_done_res, want.done_res);
    check_field("total_count", out_total_count, want.total_count);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_taken) begin
        if (char_queue.size() != 0 && (steady || $urandom_range(0, 99) >= 9)) begin
          in_valid <= 1'b1;
          in_char_code <= char_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= !steady && ($urandom_range(0, 99) < 9);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      in_taken = rst_n && in_valid && !in_stall;
      if (in_taken) begin
        parse_char(in_char_code);
        accepted_count++;
      end
      if (rst_n && out_valid && !out_stall) begin
        check_word();
      end
    end
  end

  task automatic add_char(input logic [dilp_pkg::CharW-1:0] ch);
    char_queue.push_back(ch);
    queued_count++;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i]);
    end
  endtask

  function automatic logic [dilp_pkg::CharW-1:0] pick_separator();
    logic [dilp_pkg::CharW-1:0] c;
    if ($urandom_range(0, 1) == 0) begin
      return CHAR_COMMA;
    end
    do begin
      c = dilp_pkg::CharW'($urandom_range(1, 255));
    end while ((c >= dilp_pkg::CHAR_ZERO && c <= dilp_pkg::CHAR_NINE) ||
               c == dilp_pkg::CHAR_MINUS);
    return c;
  endfunction

  task automatic add_random_string(input int max_tokens);
    int n_tok;
    int n_dig;
    n_tok = $urandom_range(0, max_tokens);
    for (int t = 0; t < n_tok; t++) begin
      case ($urandom_range(0, 19))
        0: begin
          add_char(dilp_pkg::CharW'($urandom_range(1, 255)));
        end
        1: begin
          add_char(dilp_pkg::CHAR_MINUS);
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            add_char(dilp_pkg::CHAR_MINUS);
          end
          n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 5);
          for (int k = 0; k < n_dig; k++) begin
            add_char(dilp_pkg::CHAR_ZERO + dilp_pkg::CharW'($urandom_range(0, 9)));
          end
        end
      endcase
      if ($urandom_range(0, 4) != 0) begin
        add_char(pick_separator());
      end
    end
    add_char(dilp_pkg::CHAR_TERM);
  endtask

  task automatic drain();
    do begin
      @(negedge clk);
    end while (accepted_count != queued_count || expected_results.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  task automatic run_strings(input int n_chars, input int max_tokens);
    int target;
    @(posedge clk);
    target = queued_count + n_chars;
    while (queued_count < target) begin
      add_random_string(max_tokens);
    end
    drain();
  endtask

  task automatic write_max_values(input logic [dilp_pkg::CountW-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= dilp_pkg::ADDR_MAX_VALUES;
    pwdata <= dilp_pkg::DataW'(v);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    max_values_q = v;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== dilp_pkg::DataW'(v)) begin
      report($sformatf("max_values readback %0h, expected %0h", prdata, v));
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: signs, minus inside a number, lone minus, high codes, saturation
    @(posedge clk);
    add_text("-7,12-3 -");
    add_char(dilp_pkg::CHAR_TERM);
    add_char(8'hFF);
    add_char(dilp_pkg::CHAR_ZERO);
    add_char(8'h80);
    add_char(dilp_pkg::CHAR_TERM);
    add_text("9223372036854775807 9223372036854775808,-42");
    add_char(dilp_pkg::CHAR_TERM);
    drain();

    // list full
    write_max_values(16'd1);
    @(posedge clk);
    add_text("5 6");
    add_char(dilp_pkg::CHAR_TERM);
    drain();

    // limit lowered while a number is pending
    write_max_values(16'd16);
    @(posedge clk);
    add_text("1 23");
    drain();
    write_max_values(16'd1);
    @(posedge clk);
    add_char("4");
    add_char(dilp_pkg::CHAR_TERM);
    drain();

    write_max_values(16'd0);
    @(posedge clk);
    add_char("8");
    add_char(dilp_pkg::CHAR_TERM);
    drain();

    // random strings under several limits
    write_max_values(dilp_pkg::MAX_VALUES_RESET);
    run_strings(300, 24);
    write_max_values(16'hFFFF);
    steady = 1'b1;
    run_strings(300, 12);
    steady = 1'b0;
    write_max_values(16'd1);
    run_strings(150, 6);
    write_max_values(16'd0);
    run_strings(60, 4);
    write_max_values(16'd3);
    run_strings(200, 8);
    write_max_values(dilp_pkg::CountW'($urandom_range(2, 65535)));
    run_strings(300, 10);

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
